>>> src/rws_pkg.sv
// rws_pkg: shared widths, constants, codes and types of the raycast wall-slice block
// no dependencies; imported by the channel interfaces and every module
package rws_pkg;

  // screen geometry
  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 512;

  // fixed-point formats
  localparam int FRAC_W   = 16;
  localparam int COL_W    = 10;
  localparam int CELL_W   = 8;
  localparam int POS_W    = 24;
  localparam int VEC_W    = 19;
  localparam int CAM_W    = 18;
  localparam int RAY_W    = 21;
  localparam int NUM_W    = 26;
  localparam int AN_W     = 25;
  localparam int AR_W     = 20;
  localparam int DIST_W   = 24;
  localparam int HGT_W    = 16;
  localparam int TEXW_W   = 13;
  localparam int TEXC_W   = 12;
  localparam int ROW_W    = 9;
  localparam int AN_LO_W  = DIST_W - FRAC_W;
  localparam int ADDR_W   = 5;

  localparam logic [DIST_W-1:0] DIST_MAX   = '1;
  localparam logic [HGT_W-1:0]  HEIGHT_MAX = '1;

  // wall faces
  localparam logic [1:0] FACE_EAST  = 2'd0;
  localparam logic [1:0] FACE_WEST  = 2'd1;
  localparam logic [1:0] FACE_NORTH = 2'd2;
  localparam logic [1:0] FACE_SOUTH = 2'd3;

  // register map, word index
  typedef enum logic [2:0] {
    REG_POS_X     = 3'd0,
    REG_POS_Y     = 3'd1,
    REG_DIR_X     = 3'd2,
    REG_DIR_Y     = 3'd3,
    REG_PLANE_X   = 3'd4,
    REG_PLANE_Y   = 3'd5,
    REG_TEX_WIDTH = 3'd6
  } reg_idx_t;

  typedef logic signed [RAY_W-1:0] ray_t;

  // sideband that rides along the distance divider
  typedef struct packed {
    logic               neg;
    logic               zero;
    logic               sat;
    logic [AN_LO_W-1:0] an_lo;
    logic [AR_W-1:0]    ar;
    ray_t               ray_other;
    logic               side;
    logic [1:0]         face;
    logic               mirror;
  } dsb_t;

  // transaction entering the height divider
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] distance;
    logic [TEXC_W-1:0] tex_column;
    logic [1:0]        wall_face;
  } hd_in_t;

  // transaction leaving the height divider
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] distance;
    logic [HGT_W-1:0]  height;
    logic [TEXC_W-1:0] tex_column;
    logic [1:0]        wall_face;
  } hd_out_t;

endpackage

>>> src/rws_in_if.sv
// rws_in_if: input channel carrying one column hit transaction
// depends on rws_pkg
interface rws_in_if import rws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  column;
  logic [CELL_W-1:0] hit_cell_x;
  logic [CELL_W-1:0] hit_cell_y;
  logic              hit_side;

  modport source (output valid, column, hit_cell_x, hit_cell_y, hit_side, input ready);
  modport sink (input valid, column, hit_cell_x, hit_cell_y, hit_side, output ready);
endinterface

>>> src/rws_out_if.sv
// rws_out_if: output channel carrying one wall-slice transaction
// depends on rws_pkg
interface rws_out_if import rws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] perp_distance;
  logic [HGT_W-1:0]  line_height;
  logic [ROW_W-1:0]  draw_start;
  logic [ROW_W-1:0]  draw_end;
  logic [1:0]        wall_face;
  logic [TEXC_W-1:0] tex_column;

  modport source (output valid, perp_distance, line_height, draw_start, draw_end,
                  wall_face, tex_column, input ready);
  modport sink (input valid, perp_distance, line_height, draw_start, draw_end,
                wall_face, tex_column, output ready);
endinterface

>>> src/rws_height_div.sv
// rws_height_div: pipelined restoring divider, line height = SCREEN_HEIGHT*2^16 / dist
// one quotient bit per stage; depends on rws_pkg
module rws_height_div import rws_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  hd_in_t  din,
  output hd_out_t dout
);

  localparam int NSTG = HGT_W;

  logic              v   [0:NSTG];
  logic [DIST_W-1:0] rem [0:NSTG];
  logic [HGT_W-1:0]  q   [0:NSTG];
  logic [DIST_W-1:0] dv  [0:NSTG];
  logic              sat [0:NSTG];
  logic [TEXC_W-1:0] tc  [0:NSTG];
  logic [1:0]        fc  [0:NSTG];

  // stage 0 seeds the remainder with the integer part of the dividend
  assign v[0]   = din.valid;
  assign rem[0] = DIST_W'(SCREEN_HEIGHT);
  assign q[0]   = '0;
  assign dv[0]  = din.distance;
  assign sat[0] = (din.distance <= DIST_W'(SCREEN_HEIGHT));
  assign tc[0]  = din.tex_column;
  assign fc[0]  = din.wall_face;

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic [DIST_W:0] trial;
    logic            ge;

    // shift in a zero, subtract when it fits
    assign trial = {rem[k], 1'b0};
    assign ge    = (trial >= {1'b0, dv[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? DIST_W'(trial - {1'b0, dv[k]}) : trial[DIST_W-1:0];
        q[k+1]   <= q[k] | (HGT_W'(ge) << (NSTG - 1 - k));
        dv[k+1]  <= dv[k];
        sat[k+1] <= sat[k];
        tc[k+1]  <= tc[k];
        fc[k+1]  <= fc[k];
      end
    end
  end

  // saturate for distances at or below the screen height, including zero
  assign dout.valid      = v[NSTG];
  assign dout.distance   = dv[NSTG];
  assign dout.height     = sat[NSTG] ? HEIGHT_MAX : q[NSTG];
  assign dout.tex_column = tc[NSTG];
  assign dout.wall_face  = fc[NSTG];

endmodule

>>> src/raycast_wall_slice.sv
// raycast_wall_slice: wall-slice projection for one screen column of a grid raycaster
// channels: in_ch takes column, hit_cell_x, hit_cell_y, hit_side; out_ch returns
// perp_distance, line_height, draw_start, draw_end, wall_face, tex_column.
// an APB-style port writes the camera registers (pos, dir, plane, tex_width);
// write them only while no transaction is in flight.
// the pipeline runs from input to output register: two stages form the ray,
// 24 stages run the distance divider (one quotient bit each), three stages finish
// the distance and texture column, 16 stages run the height divider, one stage
// clamps the draw rows into the output register.
// throughput is one transaction per cycle; the 40 divider stages set the latency.
// the whole pipeline advances whenever the output register is empty or taken, so
// a stall at out_ch holds every stage and in_ch.ready falls with it.
// reset (rst, synchronous) clears all valid bits and loads the default camera.
// depends on rws_pkg, rws_in_if, rws_out_if, rws_height_div
module raycast_wall_slice import rws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  rws_in_if.sink            in_ch,
  rws_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int DSTG = DIST_W;

  // camera registers
  logic [POS_W-1:0]         pos_x, pos_y;
  logic signed [VEC_W-1:0]  dir_x, dir_y, plane_x, plane_y;
  logic [TEXW_W-1:0]        tex_width;

  logic adv;
  logic out_valid;

  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign pready      = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= POS_W'(8388608);
      pos_y     <= POS_W'(8388608);
      dir_x     <= VEC_W'(65536);
      dir_y     <= '0;
      plane_x   <= '0;
      plane_y   <= VEC_W'(43253);
      tex_width <= TEXW_W'(64);
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_POS_X:     pos_x     <= pwdata[POS_W-1:0];
        REG_POS_Y:     pos_y     <= pwdata[POS_W-1:0];
        REG_DIR_X:     dir_x     <= pwdata[VEC_W-1:0];
        REG_DIR_Y:     dir_y     <= pwdata[VEC_W-1:0];
        REG_PLANE_X:   plane_x   <= pwdata[VEC_W-1:0];
        REG_PLANE_Y:   plane_y   <= pwdata[VEC_W-1:0];
        REG_TEX_WIDTH: tex_width <= pwdata[TEXW_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_POS_X:     prdata = {8'd0, pos_x};
      REG_POS_Y:     prdata = {8'd0, pos_y};
      REG_DIR_X:     prdata = {{(32-VEC_W){dir_x[VEC_W-1]}}, dir_x};
      REG_DIR_Y:     prdata = {{(32-VEC_W){dir_y[VEC_W-1]}}, dir_y};
      REG_PLANE_X:   prdata = {{(32-VEC_W){plane_x[VEC_W-1]}}, plane_x};
      REG_PLANE_Y:   prdata = {{(32-VEC_W){plane_y[VEC_W-1]}}, plane_y};
      REG_TEX_WIDTH: prdata = {19'd0, tex_width};
      default:       prdata = '0;
    endcase
  end

  // stage 1: camera x and plane products
  logic [31:0]             cam_full;
  logic signed [CAM_W-1:0] cam;
  logic signed [36:0]      px_prod, py_prod;
  logic                    s1_valid;
  logic signed [36:0]      s1_px, s1_py;
  logic                    s1_side;
  logic [CELL_W-1:0]       s1_cx, s1_cy;

  assign cam_full = ({22'd0, in_ch.column} << (FRAC_W + 1)) / SCREEN_WIDTH - (32'd1 << FRAC_W);
  assign cam      = cam_full[CAM_W-1:0];
  assign px_prod  = 37'(plane_x) * 37'(cam);
  assign py_prod  = 37'(plane_y) * 37'(cam);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px   <= px_prod;
      s1_py   <= py_prod;
      s1_side <= in_ch.hit_side;
      s1_cx   <= in_ch.hit_cell_x;
      s1_cy   <= in_ch.hit_cell_y;
    end
  end

  // stage 2: ray, distance numerator, magnitudes and flags
  ray_t                    ray_x, ray_y, ray_hit;
  logic [CELL_W-1:0]       hit_cell;
  logic [POS_W-1:0]        pos_hit;
  logic signed [NUM_W-1:0] num;
  logic [AN_W-1:0]         an;
  logic [AR_W-1:0]         ar;
  dsb_t                    sb2;

  assign ray_x    = RAY_W'(dir_x) + RAY_W'(s1_px >>> FRAC_W);
  assign ray_y    = RAY_W'(dir_y) + RAY_W'(s1_py >>> FRAC_W);
  assign ray_hit  = s1_side ? ray_y : ray_x;
  assign hit_cell = s1_side ? s1_cy : s1_cx;
  assign pos_hit  = s1_side ? pos_y : pos_x;
  assign num      = $signed({2'b00, hit_cell, 16'd0}) - $signed({2'b00, pos_hit})
                    + (ray_hit < 0 ? NUM_W'(1 << FRAC_W) : NUM_W'(0));
  assign an       = num < 0 ? AN_W'(-num) : AN_W'(num);
  assign ar       = ray_hit < 0 ? AR_W'(-ray_hit) : AR_W'(ray_hit);

  always_comb begin
    sb2.neg       = num[NUM_W-1] ^ ray_hit[RAY_W-1];
    sb2.zero      = (ray_hit == 0);
    // quotient would not fit in 24 bits
    sb2.sat       = ({3'd0, an} >= {ar, 8'd0});
    sb2.an_lo     = an[AN_LO_W-1:0];
    sb2.ar        = ar;
    sb2.ray_other = s1_side ? ray_x : ray_y;
    sb2.side      = s1_side;
    if (!s1_side) begin
      sb2.face   = ray_x < 0 ? FACE_EAST : FACE_WEST;
      sb2.mirror = ray_x > 0;
    end else begin
      sb2.face   = ray_y < 0 ? FACE_NORTH : FACE_SOUTH;
      sb2.mirror = ray_y < 0;
    end
  end

  // distance divider stages, index 0 is the stage 2 register
  logic              d_valid [0:DSTG];
  logic [AR_W-1:0]   d_rem   [0:DSTG];
  logic [DIST_W-1:0] d_q     [0:DSTG];
  dsb_t              d_sb    [0:DSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else if (adv) begin
      d_valid[0] <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_rem[0] <= AR_W'(an >> AN_LO_W);
      d_q[0]   <= '0;
      d_sb[0]  <= sb2;
    end
  end

  for (genvar k = 0; k < DSTG; k++) begin : g_dstage
    localparam int BIT = DSTG - 1 - k;
    logic          nb;
    logic [AR_W:0] trial;
    logic          ge;

    // next dividend bit: low bits of |num| then zeros
    if (BIT >= FRAC_W) begin : g_data
      assign nb = d_sb[k].an_lo[BIT-FRAC_W];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign trial = {d_rem[k], nb};
    assign ge    = (trial >= {1'b0, d_sb[k].ar});

    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[k+1] <= 1'b0;
      end else if (adv) begin
        d_valid[k+1] <= d_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_rem[k+1] <= ge ? AR_W'(trial - {1'b0, d_sb[k].ar}) : trial[AR_W-1:0];
        d_q[k+1]   <= d_q[k] | (DIST_W'(ge) << BIT);
        d_sb[k+1]  <= d_sb[k];
      end
    end
  end

  // finish distance: zero ray and overflow saturate, wall behind gives zero
  logic              f_valid;
  logic [DIST_W-1:0] f_dist;
  dsb_t              f_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= d_valid[DSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (d_sb[DSTG].zero) begin
        f_dist <= DIST_MAX;
      end else if (d_sb[DSTG].neg) begin
        f_dist <= '0;
      end else if (d_sb[DSTG].sat) begin
        f_dist <= DIST_MAX;
      end else begin
        f_dist <= d_q[DSTG];
      end
      f_sb <= d_sb[DSTG];
    end
  end

  // wall hit position fraction
  logic signed [45:0] w_prod;
  logic [POS_W-1:0]   pos_other;
  logic               p_valid;
  logic [FRAC_W-1:0]  p_frac;
  logic [DIST_W-1:0]  p_dist;
  dsb_t               p_sb;

  assign w_prod    = 46'($signed({1'b0, f_dist})) * 46'(f_sb.ray_other);
  assign pos_other = f_sb.side ? pos_x : pos_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_frac <= pos_other[FRAC_W-1:0] + w_prod[2*FRAC_W-1:FRAC_W];
      p_dist <= f_dist;
      p_sb   <= f_sb;
    end
  end

  // texture column with mirroring
  logic [FRAC_W+TEXW_W-1:0] t_prod;
  logic [TEXW_W-1:0]        t_col, t_mir, t_sel;
  hd_in_t                   hd_in;
  hd_out_t                  hd_out;

  assign t_prod = (FRAC_W+TEXW_W)'(p_frac) * (FRAC_W+TEXW_W)'(tex_width);
  assign t_col  = t_prod[FRAC_W+TEXW_W-1:FRAC_W];
  assign t_mir  = tex_width - t_col - TEXW_W'(1);
  assign t_sel  = (tex_width == 0) ? '0 : (p_sb.mirror ? t_mir : t_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      hd_in.valid <= 1'b0;
    end else if (adv) begin
      hd_in.valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hd_in.distance   <= p_dist;
      hd_in.tex_column <= t_sel[TEXC_W-1:0];
      hd_in.wall_face  <= p_sb.face;
    end
  end

  rws_height_div u_height_div (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .din  (hd_in),
    .dout (hd_out)
  );

  // draw rows clamped to the screen, then the output register
  logic [HGT_W-2:0]   half;
  logic signed [17:0] row_start, row_end;

  assign half      = hd_out.height[HGT_W-1:1];
  assign row_start = 18'(SCREEN_HEIGHT / 2) - $signed({3'd0, half});
  assign row_end   = 18'(SCREEN_HEIGHT / 2) + $signed({3'd0, half});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= hd_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.perp_distance <= hd_out.distance;
      out_ch.line_height   <= hd_out.height;
      out_ch.draw_start    <= row_start < 0 ? '0 : row_start[ROW_W-1:0];
      out_ch.draw_end      <= row_end >= 18'(SCREEN_HEIGHT) ? ROW_W'(SCREEN_HEIGHT - 1)
                                                           : row_end[ROW_W-1:0];
      out_ch.wall_face     <= hd_out.wall_face;
      out_ch.tex_column    <= hd_out.tex_column;
    end
  end

  assign out_ch.valid = out_valid;

`ifndef SYNTHESIS
  // the slice never starts below its end
  a_rows_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ch.draw_start <= out_ch.draw_end))
    else $error("draw_start above draw_end");

  // near walls saturate the height
  a_height_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ch.perp_distance <= DIST_W'(SCREEN_HEIGHT))
      |-> (out_ch.line_height == HEIGHT_MAX))
    else $error("line height not saturated for near wall");

  // texture column stays inside the texture for widths of 1 to 4096
  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tex_width != 0 && tex_width <= TEXW_W'(4096))
      |-> ({1'b0, out_ch.tex_column} < tex_width))
    else $error("texture column out of range");

  // an empty output register always lets the pipeline move
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ch.ready)
    else $error("input stalled with empty output register");
`endif

endmodule

>>> verif/rws_tb_pkg.sv
// rws_tb_pkg: transaction types shared by the wall-slice testbench modules
// depends on rws_pkg
package rws_tb_pkg;
  import rws_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [CELL_W-1:0] hit_cell_x;
    logic [CELL_W-1:0] hit_cell_y;
    logic              hit_side;
  } hit_t;

  typedef struct packed {
    logic [DIST_W-1:0] perp_distance;
    logic [HGT_W-1:0]  line_height;
    logic [ROW_W-1:0]  draw_start;
    logic [ROW_W-1:0]  draw_end;
    logic [1:0]        wall_face;
    logic [TEXC_W-1:0] tex_column;
  } slice_t;

  // camera register file as seen by the predictor
  typedef struct {
    longint pos_x;
    longint pos_y;
    longint dir_x;
    longint dir_y;
    longint plane_x;
    longint plane_y;
    longint tex_width;
  } camera_t;
endpackage

>>> verif/rws_checker.sv
// rws_checker: watches both channels and the register port, predicts each wall slice
// and compares it field by field; depends on rws_pkg, rws_tb_pkg, rws_in_if, rws_out_if
module rws_checker import rws_pkg::*; import rws_tb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  rws_in_if.sink            in_mon,
  rws_out_if.sink           out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                errors,
  output int                slices_seen,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  camera_t cam_regs;
  slice_t  slice_q[$];

  assign pending = slice_q.size();

  function automatic longint floor16(longint v);
    longint q;
    q = v / 65536;
    if (v % 65536 != 0 && v < 0) q--;
    return q;
  endfunction

  function automatic longint sext19(logic [31:0] v);
    return longint'(signed'(v[VEC_W-1:0]));
  endfunction

  // full wall-slice projection for one hit
  function automatic slice_t project_slice(hit_t h, camera_t c);
    longint cam, rx, ry, rhit, roth, cell_idx, phit, poth, num, an, ar, q, distance;
    longint hgt, half, st, en, wall, frac, texc;
    logic   neg;
    slice_t s;
    cam  = (2 * longint'(h.column) * 65536) / SCREEN_WIDTH - 65536;
    rx   = c.dir_x + floor16(c.plane_x * cam);
    ry   = c.dir_y + floor16(c.plane_y * cam);
    rhit = h.hit_side ? ry : rx;
    roth = h.hit_side ? rx : ry;
    cell_idx = h.hit_side ? longint'(h.hit_cell_y) : longint'(h.hit_cell_x);
    phit = h.hit_side ? c.pos_y : c.pos_x;
    poth = h.hit_side ? c.pos_x : c.pos_y;
    num  = cell_idx * 65536 - phit + (rhit < 0 ? 65536 : 0);
    if (rhit == 0) distance = 'hFFFFFF;
    else begin
      neg = (num < 0) != (rhit < 0);
      an  = num < 0 ? -num : num;
      ar  = rhit < 0 ? -rhit : rhit;
      q   = (an * 65536) / ar;
      if (neg && q != 0) distance = 0;
      else distance = q > 'hFFFFFF ? 'hFFFFFF : q;
    end
    if (distance == 0) hgt = 65535;
    else begin
      hgt = (longint'(SCREEN_HEIGHT) * 65536) / distance;
      if (hgt > 65535) hgt = 65535;
    end
    half = hgt / 2;
    st = SCREEN_HEIGHT / 2 - half;
    en = SCREEN_HEIGHT / 2 + half;
    if (st < 0) st = 0;
    if (en >= SCREEN_HEIGHT) en = SCREEN_HEIGHT - 1;
    wall = poth + floor16(distance * roth);
    frac = wall & 'hFFFF;
    texc = 0;
    if (c.tex_width != 0) begin
      texc = (frac * c.tex_width) >> 16;
      if ((!h.hit_side && rx > 0) || (h.hit_side && ry < 0)) texc = c.tex_width - texc - 1;
    end
    s.perp_distance = distance[DIST_W-1:0];
    s.line_height   = hgt[HGT_W-1:0];
    s.draw_start    = st[ROW_W-1:0];
    s.draw_end      = en[ROW_W-1:0];
    if (!h.hit_side) s.wall_face = rx < 0 ? FACE_EAST : FACE_WEST;
    else s.wall_face = ry < 0 ? FACE_NORTH : FACE_SOUTH;
    s.tex_column    = texc[TEXC_W-1:0];
    return s;
  endfunction

  // register writes, hit predictions and slice comparisons
  always @(posedge clk) begin
    hit_t   h;
    slice_t got, exp_s;
    if (rst) begin
      cam_regs = '{8388608, 8388608, 65536, 0, 0, 43253, 64};
      errors <= 0;
      slices_seen <= 0;
      slice_q.delete();
    end else begin
      if (psel && penable && pwrite) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_POS_X:     cam_regs.pos_x     = pwdata[23:0];
          REG_POS_Y:     cam_regs.pos_y     = pwdata[23:0];
          REG_DIR_X:     cam_regs.dir_x     = sext19(pwdata);
          REG_DIR_Y:     cam_regs.dir_y     = sext19(pwdata);
          REG_PLANE_X:   cam_regs.plane_x   = sext19(pwdata);
          REG_PLANE_Y:   cam_regs.plane_y   = sext19(pwdata);
          REG_TEX_WIDTH: cam_regs.tex_width = pwdata[TEXW_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        h = '{in_mon.column, in_mon.hit_cell_x, in_mon.hit_cell_y, in_mon.hit_side};
        slice_q.push_back(project_slice(h, cam_regs));
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.perp_distance, out_mon.line_height, out_mon.draw_start,
                out_mon.draw_end, out_mon.wall_face, out_mon.tex_column};
        slices_seen <= slices_seen + 1;
        if (slice_q.size() == 0) begin
          $error("slice with no prediction waiting");
          errors <= errors + 1;
        end else begin
          exp_s = slice_q.pop_front();
          if (got != exp_s) errors <= errors + 1;
          if (got.perp_distance != exp_s.perp_distance)
            $error("perp_distance exp %0d got %0d", exp_s.perp_distance, got.perp_distance);
          if (got.line_height != exp_s.line_height)
            $error("line_height exp %0d got %0d", exp_s.line_height, got.line_height);
          if (got.draw_start != exp_s.draw_start)
            $error("draw_start exp %0d got %0d", exp_s.draw_start, got.draw_start);
          if (got.draw_end != exp_s.draw_end)
            $error("draw_end exp %0d got %0d", exp_s.draw_end, got.draw_end);
          if (got.wall_face != exp_s.wall_face)
            $error("wall_face exp %0d got %0d", exp_s.wall_face, got.wall_face);
          if (got.tex_column != exp_s.tex_column)
            $error("tex_column exp %0d got %0d", exp_s.tex_column, got.tex_column);
        end
      end
    end
  end
endmodule

>>> verif/tb_raycast_wall_slice.sv
// tb_raycast_wall_slice: stimulus, register phases and verdict for raycast_wall_slice
// depends on rws_pkg, rws_tb_pkg, rws_in_if, rws_out_if, rws_checker and the block
module tb_raycast_wall_slice;
  import rws_pkg::*;
  import rws_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 60;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              calm = 1'b0;
  int                errors, slices_seen, pending, idle_cycles = 0, hits_sent = 0;

  rws_in_if  in_ch();
  rws_out_if out_ch();

  raycast_wall_slice dut (.clk, .rst, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready);

  rws_checker chk (.clk, .rst, .in_mon(in_ch.sink), .out_mon(out_ch.sink), .psel,
    .penable, .pwrite, .paddr, .pwdata, .errors, .slices_seen, .pending);

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.column = '0;
    in_ch.hit_cell_x = '0;
    in_ch.hit_cell_y = '0;
    in_ch.hit_side = 1'b0;
    out_ch.ready = 1'b0;
  end

  // random back-pressure on the result side
  always @(posedge clk) out_ch.ready <= calm || ($urandom_range(99) >= 33);

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else if (!rst && !psel) idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("raycast_wall_slice regression: fail");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_hit(hit_t h);
    while (!calm && $urandom_range(99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.column, in_ch.hit_cell_x, in_ch.hit_cell_y, in_ch.hit_side} <= h;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    hits_sent++;
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // near hits: cells within 3 of the viewer's cell, with random column and side
  function automatic hit_t near_hit(logic [23:0] px, logic [23:0] py);
    hit_t h;
    h.column     = COL_W'($urandom);
    h.hit_side   = 1'($urandom);
    h.hit_cell_x = px[23:16] + 8'($urandom_range(6)) - 8'd3;
    h.hit_cell_y = py[23:16] + 8'($urandom_range(6)) - 8'd3;
    return h;
  endfunction

  task automatic random_phase(int n, logic [23:0] px, logic [23:0] py);
    hit_t h;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) h = near_hit(px, py);
      else h = hit_t'($bits(hit_t)'($urandom));
      send_hit(h);
    end
    end_burst();
  endtask

  task automatic load_camera(logic [23:0] px, logic [23:0] py, logic [18:0] dx,
                             logic [18:0] dy, logic [18:0] qx, logic [18:0] qy,
                             logic [12:0] tw);
    write_reg(REG_POS_X, 32'(px));
    write_reg(REG_POS_Y, 32'(py));
    write_reg(REG_DIR_X, 32'(dx));
    write_reg(REG_DIR_Y, 32'(dy));
    write_reg(REG_PLANE_X, 32'(qx));
    write_reg(REG_PLANE_Y, 32'(qy));
    write_reg(REG_TEX_WIDTH, 32'(tw));
  endtask

  initial begin
    logic [23:0] px, py;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes at the reset camera, zero ray, behind viewer, on cell
    send_hit('{10'd0, 8'd0, 8'd0, 1'b0});
    send_hit('{10'd1023, 8'd255, 8'd255, 1'b1});
    send_hit('{10'd512, 8'd129, 8'd128, 1'b0});
    send_hit('{10'd512, 8'd128, 8'd128, 1'b0});
    send_hit('{10'd512, 8'd130, 8'd128, 1'b1});
    send_hit('{10'd0, 8'd127, 8'd130, 1'b1});
    send_hit('{10'd1023, 8'd200, 8'd60, 1'b1});
    send_hit('{10'd300, 8'd140, 8'd0, 1'b0});
    end_burst();

    // extremes: cameras at both map corners, vectors at both ends, zero texture width
    load_camera(24'h0, 24'h0, 19'h40000, 19'h40000, 19'h40000, 19'h3FFFF, 13'd0);
    send_hit('{10'd0, 8'd0, 8'd0, 1'b0});
    send_hit('{10'd1023, 8'd0, 8'd0, 1'b1});
    send_hit('{10'd511, 8'd255, 8'd1, 1'b0});
    end_burst();
    load_camera(24'hFFFFFF, 24'hFFFFFF, 19'h3FFFF, 19'h3FFFF, 19'h3FFFF, 19'h40000, 13'h1FFF);
    send_hit('{10'd0, 8'd255, 8'd255, 1'b0});
    send_hit('{10'd1023, 8'd0, 8'd255, 1'b1});
    send_hit('{10'd700, 8'd254, 8'd3, 1'b1});
    end_burst();
    load_camera(24'h808000, 24'h404000, 19'h0, 19'h10000, 19'h0, 19'h0, 13'd4096);
    send_hit('{10'd100, 8'd128, 8'd66, 1'b0});
    send_hit('{10'd100, 8'd128, 8'd66, 1'b1});
    send_hit('{10'd900, 8'd129, 8'd64, 1'b1});
    end_burst();

    // random phases: one calm stretch, then random cameras
    calm = 1'b1;
    load_camera(24'h800000, 24'h800000, 19'd65536, 19'd0, 19'd0, 19'd43253, 13'd64);
    random_phase(100, 24'h800000, 24'h800000);
    calm = 1'b0;
    for (int p = 0; p < 10; p++) begin
      px = 24'($urandom);
      py = 24'($urandom);
      load_camera(px, py, 19'($urandom), 19'($urandom), 19'($urandom), 19'($urandom),
                  (p % 3 == 0) ? 13'($urandom) : 13'($urandom_range(4096, 1)));
      random_phase(105, px, py);
    end

    $display("sent %0d hits over 14 camera settings, checked %0d slices",
             hits_sent, slices_seen);
    if (errors == 0 && pending == 0) begin
      $display("raycast_wall_slice regression: pass");
    end else begin
      $display("raycast_wall_slice regression: fail");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/rws_pkg.sv
src/rws_in_if.sv
src/rws_out_if.sv
src/rws_height_div.sv
src/raycast_wall_slice.sv
verif/rws_tb_pkg.sv
verif/rws_checker.sv
verif/tb_raycast_wall_slice.sv
